FILE: hdl/gyro_bias_calibrate_and_scale_assert.svh
// Assertion macros for the gyro bias block.
`ifndef GYRO_BIAS_CALIBRATE_AND_SCALE_ASSERT_SVH
`define GYRO_BIAS_CALIBRATE_AND_SCALE_ASSERT_SVH

// Checked outside reset only.
`define GBCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define GBCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

FILE: hdl/gbcs_pkg.sv
package gbcs_pkg;

  localparam int unsigned AXES            = 3;
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned SUM_W           = 32;
  localparam int unsigned CNT_W           = 16;
  localparam int unsigned SHIFT_W         = 2;
  localparam int unsigned PROD_W          = 22;  // 16-bit sample times 35
  localparam int unsigned RATE_W          = 25;
  localparam int unsigned RATE_MUL        = 35;  // 8.75 mdps in 0.25 mdps units
  localparam logic [AXES-1:0] AXIS_NEG    = 3'b011;  // X and Y flipped
  localparam int unsigned CAL_SAMPLES_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    KIND_CAL,   // still averaging
    KIND_LAST,  // completes the average
    KIND_RUN    // bias already fixed
  } kind_e;

  typedef logic [AXES-1:0][SAMPLE_W-1:0] sample_vec_t;
  typedef logic [AXES-1:0][SUM_W-1:0]    sum_vec_t;

  typedef struct packed {
    kind_e       kind;
    sample_vec_t raw;
  } item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/gbcs_front.sv
module gbcs_front import gbcs_pkg::*; #(
  parameter int unsigned CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  sample_vec_t in_raw_i,
  output logic        push_o,
  output item_t       item_o,
  output sum_vec_t    sums_o
);

  localparam int unsigned DIVISOR = (CAL_SAMPLES < 1) ? 1 : CAL_SAMPLES;

  logic             done_q, done_d;
  logic [CNT_W-1:0] count_q, count_d;
  sum_vec_t         sums_q, sums_d;
  logic [CNT_W:0]   count_inc;
  logic             accept, last;

  assign accept    = in_valid_i && in_ready_i;
  assign count_inc = {1'b0, count_q} + (CNT_W+1)'(1);
  assign last      = count_inc >= (CNT_W+1)'(DIVISOR);

  always_comb begin
    done_d  = done_q;
    count_d = count_q;
    sums_d  = sums_q;
    if (accept && !done_q) begin
      count_d = count_inc[CNT_W-1:0];
      done_d  = last;
      for (int i = 0; i < AXES; i++) begin
        sums_d[i] = sums_q[i] + {{(SUM_W-SAMPLE_W){in_raw_i[i][SAMPLE_W-1]}}, in_raw_i[i]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      count_q <= '0;
      sums_q  <= '0;
    end else begin
      done_q  <= done_d;
      count_q <= count_d;
      sums_q  <= sums_d;
    end
  end

  always_comb begin
    item_o.raw = in_raw_i;
    if (done_q) begin
      item_o.kind = KIND_RUN;
    end else if (last) begin
      item_o.kind = KIND_LAST;
    end else begin
      item_o.kind = KIND_CAL;
    end
  end

  assign push_o = accept;
  assign sums_o = sums_q;

endmodule

FILE: hdl/gbcs_fifo.sv
module gbcs_fifo import gbcs_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [CNT_QW-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ptr_next(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= ptr_next(rptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_QW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_QW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  assign full_o  = count_q == CNT_QW'(DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rptr_q];

endmodule

FILE: hdl/gbcs_div.sv
module gbcs_div import gbcs_pkg::*; #(
  parameter int unsigned CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  sum_vec_t    sums_i,
  output div_stat_t   stat_o,
  output sample_vec_t bias_o
);

  localparam int unsigned DIVISOR = (CAL_SAMPLES < 1) ? 1 : CAL_SAMPLES;
  localparam int unsigned PROD_DW = 2 * SUM_W;
  // floor(2^32 / divisor), held to 32 bits; the estimate is then low by at most one
  localparam logic [PROD_DW-1:0] RECIP_FULL = (PROD_DW'(1) << SUM_W) / PROD_DW'(DIVISOR);
  localparam logic [SUM_W-1:0]   RECIP      = (DIVISOR == 1) ? {SUM_W{1'b1}}
                                                             : RECIP_FULL[SUM_W-1:0];
  localparam logic [SUM_W-1:0]   DIV_K      = SUM_W'(DIVISOR);

  // one-hot progress: magnitude, product, estimate, remainder
  logic [3:0]                   stage_q;
  logic [AXES-1:0]              neg_q;
  sum_vec_t                     mag_q, quo_q, rem_q;
  logic [AXES-1:0][PROD_DW-1:0] prod_q;
  sample_vec_t                  quo_fix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= {stage_q[2:0], start_i};
    end
  end

  // Reciprocal multiply on the magnitude, then one remainder check.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < AXES; i++) begin
      if (start_i) begin
        neg_q[i] <= sums_i[i][SUM_W-1];
        mag_q[i] <= sums_i[i][SUM_W-1] ? (~sums_i[i] + SUM_W'(1)) : sums_i[i];
      end
      if (stage_q[0]) begin
        prod_q[i] <= {{SUM_W{1'b0}}, mag_q[i]} * {{SUM_W{1'b0}}, RECIP};
      end
      if (stage_q[1]) begin
        quo_q[i] <= prod_q[i][PROD_DW-1:SUM_W];
      end
      if (stage_q[2]) begin
        rem_q[i] <= mag_q[i] - quo_q[i] * DIV_K;
      end
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      quo_fix[i] = (rem_q[i] >= DIV_K) ? (quo_q[i][SAMPLE_W-1:0] + SAMPLE_W'(1))
                                       : quo_q[i][SAMPLE_W-1:0];
      bias_o[i]  = neg_q[i] ? (~quo_fix[i] + SAMPLE_W'(1)) : quo_fix[i];
    end
  end

  assign stat_o.busy = |stage_q[2:0];
  assign stat_o.done = stage_q[3];

endmodule

FILE: hdl/gbcs_back.sv
module gbcs_back import gbcs_pkg::*; #(
  parameter int unsigned CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [SHIFT_W-1:0]            range_shift_i,
  input  sum_vec_t                      sums_i,
  input  logic                          head_valid_i,
  input  item_t                         head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          calibrated_o,
  output sample_vec_t                   corrected_o,
  output logic [AXES-1:0][RATE_W-1:0]   rate_o
);

  `include "gyro_bias_calibrate_and_scale_assert.svh"

  localparam logic signed [PROD_W-1:0] MUL = PROD_W'(RATE_MUL);

  sample_vec_t bias_q, div_bias;
  logic        bias_ok_q;
  div_stat_t   div_stat;
  logic        div_start;

  // stage A: correction and multiply
  logic                       a_valid_q, a_cal_q;
  sample_vec_t                a_corr_q;
  logic [AXES-1:0][PROD_W-1:0] a_prod_q;
  // stage B: result register
  logic                       b_valid_q, b_cal_q;
  sample_vec_t                b_corr_q;
  logic [AXES-1:0][RATE_W-1:0] b_rate_q;

  logic                       a_ready, b_ready, is_last;
  sample_vec_t                corr;
  logic [AXES-1:0][PROD_W-1:0] prod;
  logic [AXES-1:0][RATE_W-1:0] rate, scaled;

  assign is_last   = head_i.kind == KIND_LAST;
  assign b_ready   = !b_valid_q || out_ready_i;
  assign a_ready   = !a_valid_q || b_ready;
  // The completing item waits at the queue head until its bias is in place.
  assign pop_o     = head_valid_i && a_ready && (!is_last || bias_ok_q);
  assign div_start = head_valid_i && is_last && !bias_ok_q && !div_stat.busy && !div_stat.done;

  gbcs_div #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sums_i  (sums_i),
    .stat_o  (div_stat),
    .bias_o  (div_bias)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_ok_q <= 1'b0;
      bias_q    <= '0;
    end else if (div_stat.done) begin
      bias_ok_q <= 1'b1;
      bias_q    <= div_bias;
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      corr[i]   = head_i.raw[i] - bias_q[i];
      prod[i]   = PROD_W'($signed({{(PROD_W-SAMPLE_W){corr[i][SAMPLE_W-1]}}, corr[i]}) * MUL);
      scaled[i] = {{(RATE_W-PROD_W){a_prod_q[i][PROD_W-1]}}, a_prod_q[i]} << range_shift_i;
      rate[i]   = AXIS_NEG[i] ? (~scaled[i] + RATE_W'(1)) : scaled[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= pop_o;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_cal_q  <= head_i.kind != KIND_CAL;
      a_corr_q <= corr;
      a_prod_q <= prod;
    end
    if (b_ready && a_valid_q) begin
      b_cal_q  <= a_cal_q;
      b_corr_q <= a_corr_q;
      b_rate_q <= rate;
    end
  end

  assign out_valid_o  = b_valid_q;
  assign calibrated_o = b_cal_q;
  assign corrected_o  = b_corr_q;
  assign rate_o       = b_rate_q;

  `GBCS_ASSERT_ALWAYS(a_div_only_for_last,
    div_stat.busy |-> (head_valid_i && is_last && !bias_ok_q),
    "divider running without a completing item at the head")
  `GBCS_ASSERT(a_bias_from_div,
    $rose(bias_ok_q) |-> $past(div_stat.done),
    "bias marked ready without a finished division")
  `GBCS_ASSERT(a_no_cal_after_bias,
    pop_o |-> !(bias_ok_q && head_i.kind == KIND_CAL),
    "averaging item issued after the bias was fixed")

endmodule

FILE: hdl/gyro_bias_calibrate_and_scale.sv
// Gyro zero-rate bias calibration and rate scaling.
//
// Slave stream (s_axis_*) takes one raw three-axis sample per request; the
// master stream (m_axis_*) returns one result per request, in order. The
// first CAL_SAMPLES samples are summed per axis; the sample that completes
// the count fixes the bias (sum / CAL_SAMPLES, truncated toward zero) and is
// itself corrected with it. Results carry the calibrated flag in tuser, the
// corrected samples and the rates (corrected * 35 << range_shift, X and Y
// negated) in tdata. range_shift is written through cfg_we_i / cfg_wdata_i.
//
// Throughput is one request per cycle while the receiver is ready and no
// completing sample is held, set by the accumulate in the front and the
// two-stage correct/scale pipeline in the back. The completing sample
// holds at the queue head while the biases are worked out (reciprocal
// multiply, estimate, remainder check); the front keeps accepting until
// the queue of QUEUE_DEPTH entries fills.
// Reset clears sums, count, bias, flag and range_shift. A stalled receiver
// holds the result register; the queue then fills and s_axis_tready_o drops.
module gyro_bias_calibrate_and_scale import gbcs_pkg::*; #(
  parameter int unsigned CAL_SAMPLES = CAL_SAMPLES_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // tdata: raw_x [15:0], raw_y [31:16], raw_z [47:32]
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [47:0]        s_axis_tdata_i,
  // tdata: corrected_x [15:0], corrected_y [31:16], corrected_z [47:32],
  //        rate_x [72:48], rate_y [97:73], rate_z [122:98], zero fill above
  // tuser: calibrated [0]
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [127:0]       m_axis_tdata_o,
  output logic [0:0]         m_axis_tuser_o,
  input  logic               cfg_we_i,
  input  logic [SHIFT_W-1:0] cfg_wdata_i
);

  logic [SHIFT_W-1:0] range_shift_q;

  sample_vec_t in_raw;
  item_t       push_item, head;
  sum_vec_t    sums;
  logic        push, pop, full, head_valid, calibrated;
  sample_vec_t corrected;
  logic [AXES-1:0][RATE_W-1:0] rate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_shift_q <= '0;
    end else if (cfg_we_i) begin
      range_shift_q <= cfg_wdata_i;
    end
  end

  assign in_raw          = s_axis_tdata_i;
  assign s_axis_tready_o = !full;

  // front: count, sum and tag each sample
  gbcs_front #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_i (!full),
    .in_raw_i   (in_raw),
    .push_o     (push),
    .item_o     (push_item),
    .sums_o     (sums)
  );

  // queue decoupling the tagging front from the correcting back
  gbcs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .full_o      (full),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  // back: bias division, correction, scaling, result register
  gbcs_back #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .range_shift_i (range_shift_q),
    .sums_i        (sums),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .calibrated_o  (calibrated),
    .corrected_o   (corrected),
    .rate_o        (rate)
  );

  assign m_axis_tdata_o = {5'b0, rate, corrected};
  assign m_axis_tuser_o = calibrated;

endmodule
